FILE: design/world_to_screen_projection_top_assert.svh
// ---------------------------------------------------------------------------
// World-to-screen projection: assertion macros
// Shared concurrent assertion forms for the projection design files.
// ---------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define WTSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("world_to_screen_projection: assertion failed");

// next-cycle implication, disabled while in reset
`define WTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("world_to_screen_projection: assertion failed");

`endif

FILE: design/wtsp_pkg.sv
// ---------------------------------------------------------------------------
// World-to-screen projection package
// Shared constants, status codes and pipeline sideband type.
// ---------------------------------------------------------------------------
package wtsp_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int DATA_W          = 32;
    localparam int SCREEN_W        = 16;
    localparam int IDX_W           = 4;
    localparam int NUM_COEF        = 16;
    localparam int CFG_IDX_W       = 8;
    localparam int IN_TDATA_W      = 136;
    localparam int IN_TUSER_W      = 3;
    localparam int OUT_TDATA_W     = 64;
    localparam int OUT_TUSER_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

    localparam logic [SCREEN_W-1:0] RESET_WIDTH  = 16'd1920;
    localparam logic [SCREEN_W-1:0] RESET_HEIGHT = 16'd1080;

    localparam logic MAT_VIEW = 1'b0;
    localparam logic MAT_PROJ = 1'b1;

    typedef enum logic [1:0] {
        ST_PROJECTED = 2'd0,
        ST_BEHIND    = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_LOADED    = 2'd3
    } status_t;

    typedef struct packed {
        logic              is_load;
        logic              msel;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] coef;
        logic              cvis;
    } side_t;

endpackage

FILE: design/wtsp_matvec.sv
// ---------------------------------------------------------------------------
// Matrix-vector stage
// Holds one 4x4 matrix; two stages: 16 products, then row sums with saturation.
// ---------------------------------------------------------------------------
module wtsp_matvec #(
    parameter int   CW        = 32,
    parameter int   FRAC_BITS = 16,
    parameter logic SEL       = 1'b0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  wtsp_pkg::side_t       in_side,
    input  logic signed [CW-1:0]  in_vec [4],
    output logic                  out_valid,
    output wtsp_pkg::side_t       out_side,
    output logic signed [CW-1:0]  out_vec [4]
);
    localparam int PW = 2 * CW - FRAC_BITS;
    localparam int SW = PW + 2;
    localparam logic signed [CW-1:0] ONE = (FRAC_BITS < CW - 1) ?
        CW'(64'd1 << FRAC_BITS) : CW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] HI_S = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] LO_S = -HI_S - SW'(1);

    logic signed [CW-1:0]   mat_reg [wtsp_pkg::NUM_COEF];
    logic signed [2*CW-1:0] full    [wtsp_pkg::NUM_COEF];
    logic signed [PW-1:0]   prod_next [wtsp_pkg::NUM_COEF];
    logic signed [PW-1:0]   prod_reg  [wtsp_pkg::NUM_COEF];
    logic signed [SW-1:0]   acc [4];
    logic signed [CW-1:0]   vec_next [4];
    logic signed [CW-1:0]   vec_reg  [4];
    logic                   v1_reg, v2_reg;
    wtsp_pkg::side_t        s1_reg, s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < wtsp_pkg::NUM_COEF; i++) begin
                mat_reg[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (en && in_valid && in_side.is_load && in_side.msel == SEL) begin
            mat_reg[in_side.idx] <= in_side.coef[CW-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < wtsp_pkg::NUM_COEF; k++) begin
            full[k]      = (2*CW)'(mat_reg[k]) * (2*CW)'(in_vec[k % 4]);
            prod_next[k] = PW'(full[k] >>> FRAC_BITS);
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            acc[r] = SW'(prod_reg[4*r]) + SW'(prod_reg[4*r+1]) +
                     SW'(prod_reg[4*r+2]) + SW'(prod_reg[4*r+3]);
            if (acc[r] > HI_S) begin
                vec_next[r] = CW'(HI_S);
            end else if (acc[r] < LO_S) begin
                vec_next[r] = CW'(LO_S);
            end else begin
                vec_next[r] = CW'(acc[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= in_side;
            s2_reg   <= s1_reg;
            prod_reg <= prod_next;
            vec_reg  <= vec_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = s2_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: design/wtsp_div.sv
// ---------------------------------------------------------------------------
// Perspective divide
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ---------------------------------------------------------------------------
module wtsp_div #(
    parameter int CW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  wtsp_pkg::side_t       in_side,
    input  logic signed [CW-1:0]  clip [4],
    output logic                  out_valid,
    output wtsp_pkg::side_t       out_side,
    output logic                  out_behind,
    output logic signed [CW-1:0]  out_n [3]
);
    localparam int QW = CW + FRAC_BITS;
    localparam logic [QW-1:0] POS_MAX = QW'({1'b0, {(CW-1){1'b1}}});
    localparam logic [QW-1:0] NEG_MAX = QW'({1'b1, {(CW-1){1'b0}}});

    logic [CW-1:0]   rem_reg [QW+1][3];
    logic [QW-1:0]   num_reg [QW+1][3];
    logic [2:0]      neg_reg [QW+1];
    logic [CW-1:0]   d_reg   [QW+1];
    logic            beh_reg [QW+1];
    logic            val_reg [QW+1];
    wtsp_pkg::side_t side_reg [QW+1];

    logic [CW-1:0]   mag [3];
    logic signed [CW-1:0] n_next [3];
    logic signed [CW-1:0] n_reg  [3];
    logic            fin_valid_reg, fin_beh_reg;
    wtsp_pkg::side_t fin_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = clip[i][CW-1] ? CW'(-clip[i]) : CW'(clip[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg[0] <= 1'b0;
        end else if (en) begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= '0;
                num_reg[0][i] <= {mag[i], {FRAC_BITS{1'b0}}};
                neg_reg[0][i] <= clip[i][CW-1];
            end
            d_reg[0]    <= clip[3];
            beh_reg[0]  <= clip[3][CW-1] || (clip[3] == '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [CW:0]   t    [3];
        logic [CW:0]   diff [3];
        logic [2:0]    ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]    = {rem_reg[s][i], num_reg[s][i][QW-1]};
                diff[i] = t[i] - {1'b0, d_reg[s]};
                ge[i]   = (t[i] >= {1'b0, d_reg[s]});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[s+1] <= 1'b0;
            end else if (en) begin
                val_reg[s+1] <= val_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[s+1][i] <= ge[i] ? diff[i][CW-1:0] : t[i][CW-1:0];
                    num_reg[s+1][i] <= {num_reg[s][i][QW-2:0], ge[i]};
                end
                neg_reg[s+1]  <= neg_reg[s];
                d_reg[s+1]    <= d_reg[s];
                beh_reg[s+1]  <= beh_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (neg_reg[QW][i]) begin
                n_next[i] = (num_reg[QW][i] > NEG_MAX) ? CW'(NEG_MAX) :
                            CW'(-num_reg[QW][i]);
            end else begin
                n_next[i] = (num_reg[QW][i] > POS_MAX) ? CW'(POS_MAX) :
                            CW'(num_reg[QW][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= val_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg        <= n_next;
            fin_beh_reg  <= beh_reg[QW];
            fin_side_reg <= side_reg[QW];
        end
    end

    assign out_valid  = fin_valid_reg;
    assign out_side   = fin_side_reg;
    assign out_behind = fin_beh_reg;
    assign out_n      = n_reg;

endmodule

FILE: design/wtsp_viewport.sv
// ---------------------------------------------------------------------------
// Viewport mapping
// Range check and pixel scaling with flipped y; output register stage.
// ---------------------------------------------------------------------------
module wtsp_viewport #(
    parameter int CW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  wtsp_pkg::side_t                   in_side,
    input  logic                              in_behind,
    input  logic signed [CW-1:0]              in_n [3],
    input  logic [wtsp_pkg::SCREEN_W-1:0]     width,
    input  logic [wtsp_pkg::SCREEN_W-1:0]     height,
    output logic                              out_valid,
    output wtsp_pkg::status_t                 out_status,
    output logic signed [CW-1:0]              out_sx,
    output logic signed [CW-1:0]              out_sy
);
    localparam int AW = CW + 1;
    localparam int MW = AW + wtsp_pkg::SCREEN_W + 1;
    localparam logic signed [CW-1:0] ONE = (FRAC_BITS < CW - 1) ?
        CW'(64'd1 << FRAC_BITS) : CW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [CW-1:0] NEG_ONE = -ONE;
    localparam logic signed [MW-1:0] HI_M = MW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [MW-1:0] LO_M = -HI_M - MW'(1);

    wtsp_pkg::status_t    st_next, st_reg, ost_reg;
    logic signed [AW-1:0] ax, ay;
    logic signed [MW-1:0] px_next, py_next, px_reg, py_reg, hx, hy;
    logic signed [CW-1:0] sx_next, sy_next, sx_reg, sy_reg;
    logic                 v1_reg, v2_reg;
    logic                 outside;

    always_comb begin
        outside = (in_n[0] < NEG_ONE) || (in_n[0] > ONE) ||
                  (in_n[1] < NEG_ONE) || (in_n[1] > ONE) ||
                  in_n[2][CW-1] || (in_n[2] > ONE);
        if (in_side.is_load) begin
            st_next = wtsp_pkg::ST_LOADED;
        end else if (in_behind) begin
            st_next = wtsp_pkg::ST_BEHIND;
        end else if (in_side.cvis && outside) begin
            st_next = wtsp_pkg::ST_OUTSIDE;
        end else begin
            st_next = wtsp_pkg::ST_PROJECTED;
        end
        ax      = AW'(in_n[0]) + AW'(ONE);
        ay      = AW'(ONE) - AW'(in_n[1]);
        px_next = MW'(signed'({1'b0, width}))  * MW'(ax);
        py_next = MW'(signed'({1'b0, height})) * MW'(ay);
    end

    always_comb begin
        hx = px_reg >>> 1;
        hy = py_reg >>> 1;
        if (st_reg != wtsp_pkg::ST_PROJECTED) begin
            sx_next = '0;
            sy_next = '0;
        end else begin
            sx_next = (hx > HI_M) ? CW'(HI_M) : (hx < LO_M) ? CW'(LO_M) : CW'(hx);
            sy_next = (hy > HI_M) ? CW'(HI_M) : (hy < LO_M) ? CW'(LO_M) : CW'(hy);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg  <= st_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            ost_reg <= st_reg;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
        end
    end

    assign out_valid  = v2_reg;
    assign out_status = ost_reg;
    assign out_sx     = sx_reg;
    assign out_sy     = sy_reg;

endmodule

FILE: design/world_to_screen_projection_top.sv
// CW = min(COORD_WIDTH,32) throughout.
// Throughput: one transaction per cycle; the whole pipeline advances together when the
// output register is empty or taken, so the divider's CW+FRAC_BITS bit stages set latency.
// Reset: synchronous active-low aresetn clears all valid bits, loads both matrices with
// identity and the viewport with 1920 x 1080. No clearing pass.
// ---------------------------------------------------------------------------
// World-to-screen projection top
// View and projection transform, perspective divide and viewport mapping.
// ---------------------------------------------------------------------------
`include "world_to_screen_projection_top_assert.svh"

module world_to_screen_projection_top #(
    parameter int FRAC_BITS   = wtsp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = wtsp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coef_index, coef_value, point_x, point_y, point_z, zero pad
    input  logic [wtsp_pkg::IN_TDATA_W-1:0]     s_tdata,
    // req_type, matrix_select, check_visible
    input  logic [wtsp_pkg::IN_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // screen_x, screen_y
    output logic [wtsp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status
    output logic [wtsp_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtsp_pkg::DATA_W-1:0]         cfg_data
);
    localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [CW-1:0] ONE = (FRAC_BITS < CW - 1) ?
        CW'(64'd1 << FRAC_BITS) : CW'({1'b0, {(CW-1){1'b1}}});

    logic                           en;
    logic [wtsp_pkg::SCREEN_W-1:0]  width_reg, height_reg;
    wtsp_pkg::side_t                side_in, a_side_reg, eye_side, clip_side, div_side;
    logic                           a_valid_reg, eye_valid, clip_valid, div_valid;
    logic signed [CW-1:0]           p_reg [4];
    logic signed [CW-1:0]           eye [4];
    logic signed [CW-1:0]           clip [4];
    logic signed [CW-1:0]           nrm [3];
    logic                           div_behind;
    logic                           vp_valid;
    wtsp_pkg::status_t              vp_status;
    logic signed [CW-1:0]           vp_sx, vp_sy;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= wtsp_pkg::RESET_WIDTH;
            height_reg <= wtsp_pkg::RESET_HEIGHT;
        end else if (cfg_valid) begin
            case (cfg_index)
                wtsp_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[wtsp_pkg::SCREEN_W-1:0];
                wtsp_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data[wtsp_pkg::SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        side_in.is_load = !s_tuser[0];
        side_in.msel    = s_tuser[1];
        side_in.cvis    = s_tuser[2];
        side_in.idx     = s_tdata[3:0];
        side_in.coef    = s_tdata[35:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= side_in;
            p_reg[0]   <= s_tdata[36 +: CW];
            p_reg[1]   <= s_tdata[68 +: CW];
            p_reg[2]   <= s_tdata[100 +: CW];
            p_reg[3]   <= ONE;
        end
    end

    wtsp_matvec #(.CW(CW), .FRAC_BITS(FRAC_BITS), .SEL(wtsp_pkg::MAT_VIEW)) u_view (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(a_valid_reg), .in_side(a_side_reg), .in_vec(p_reg),
        .out_valid(eye_valid), .out_side(eye_side), .out_vec(eye)
    );

    wtsp_matvec #(.CW(CW), .FRAC_BITS(FRAC_BITS), .SEL(wtsp_pkg::MAT_PROJ)) u_proj (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(eye_valid), .in_side(eye_side), .in_vec(eye),
        .out_valid(clip_valid), .out_side(clip_side), .out_vec(clip)
    );

    wtsp_div #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(clip_valid), .in_side(clip_side), .clip(clip),
        .out_valid(div_valid), .out_side(div_side), .out_behind(div_behind),
        .out_n(nrm)
    );

    wtsp_viewport #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_vp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div_valid), .in_side(div_side), .in_behind(div_behind),
        .in_n(nrm), .width(width_reg), .height(height_reg),
        .out_valid(vp_valid), .out_status(vp_status), .out_sx(vp_sx), .out_sy(vp_sy)
    );

    assign m_tvalid = vp_valid;
    assign m_tuser  = vp_status;
    assign m_tdata  = {32'(vp_sy), 32'(vp_sx)};

    `WTSP_ASSERT_NOW(a_reject_zero, aclk, aresetn, m_tvalid && m_tuser != wtsp_pkg::ST_PROJECTED, m_tdata == '0)
    `WTSP_ASSERT_NOW(a_stall_holds_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `WTSP_ASSERT_NEXT(a_cfg_width, aclk, aresetn, cfg_valid && cfg_index == wtsp_pkg::CFG_SCREEN_WIDTH, width_reg == $past(cfg_data[wtsp_pkg::SCREEN_W-1:0]))

endmodule
